>>> hw/rtl/rtpv_pkg.sv
package rtpv_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;

	// Trig values are signed Q1.14
	localparam int TRIG_W    = 16;
	localparam int TRIG_FRAC = 14;
	localparam int TRIG_LAT  = 5;
	localparam int POLY_A    = 25736;
	localparam int POLY_B    = 10512;
	localparam int POLY_C    = 1160;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET   = 8'd1;

	localparam logic [15:0] DEPTH_OFFSET_RST = 16'd4096;

	typedef struct packed {
		logic valid;
		logic behind;
		logic neg_x;
		logic neg_y;
	} rtpv_ctl_t;

endpackage

>>> hw/rtl/rtpv_trig.sv
module rtpv_trig
	import rtpv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [15:0]              phase,
	output logic signed [TRIG_W-1:0] sine
);

	logic [1:0]  quad;
	logic [13:0] r;
	logic [14:0] u;
	logic [29:0] uu;

	logic [14:0] u_s1, u_s2, u_s3;
	logic [15:0] u2_s1, u2_s2;
	logic [3:0]  neg_q;
	logic [13:0] t1_s2;
	logic [14:0] t2_s3;
	logic [15:0] f_s4;

	logic [29:0] p2, p3, p4;

	assign quad = phase[15:14];
	assign r    = phase[13:0];
	assign u    = quad[0] ? (15'd16384 - 15'(r)) : 15'(r);
	assign uu   = 30'(u) * 30'(u);
	assign p2   = 30'(u2_s1) * 30'(POLY_C);
	assign p3   = 30'(u2_s2) * 30'(t1_s2);
	assign p4   = 30'(u_s3) * 30'(t2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= '0;
		end else begin
			neg_q <= {neg_q[2:0], quad[1]};
		end
	end

	always_ff @(posedge clk) begin
		u_s1  <= u;
		u2_s1 <= uu[29:14];
		u_s2  <= u_s1;
		u2_s2 <= u2_s1;
		t1_s2 <= 14'(POLY_B) - p2[27:14];
		u_s3  <= u_s2;
		t2_s3 <= 15'(POLY_A) - p3[28:14];
		f_s4  <= p4[29:14];
		sine  <= neg_q[3] ? -$signed(f_s4) : $signed(f_s4);
	end

endmodule

>>> hw/rtl/rtpv_div_cell.sv
module rtpv_div_cell
	import rtpv_pkg::*;
#(
	parameter int NW = 31,
	parameter int DW = 20,
	parameter int QW = 17,
	parameter int CW = 40,
	parameter int CB = 16,
	parameter int K  = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  rtpv_ctl_t       ctl_in,
	input  logic [NW-1:0]   rx_in,
	input  logic [NW-1:0]   ry_in,
	input  logic [DW-1:0]   den_in,
	input  logic [QW-1:0]   qx_in,
	input  logic [QW-1:0]   qy_in,
	input  logic [CB-1:0]   depth_in,
	output rtpv_ctl_t       ctl_out,
	output logic [NW-1:0]   rx_out,
	output logic [NW-1:0]   ry_out,
	output logic [DW-1:0]   den_out,
	output logic [QW-1:0]   qx_out,
	output logic [QW-1:0]   qy_out,
	output logic [CB-1:0]   depth_out
);

	logic [CW-1:0] dsh, ex, ey, sx, sy;
	logic          gx, gy;

	assign dsh = CW'(den_in) << K;
	assign ex  = CW'(rx_in);
	assign ey  = CW'(ry_in);
	assign gx  = ex >= dsh;
	assign gy  = ey >= dsh;
	assign sx  = ex - dsh;
	assign sy  = ey - dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_out    <= gx ? NW'(sx) : rx_in;
			ry_out    <= gy ? NW'(sy) : ry_in;
			qx_out    <= qx_in | (QW'(gx) << K);
			qy_out    <= qy_in | (QW'(gy) << K);
			den_out   <= den_in;
			depth_out <= depth_in;
		end
	end

endmodule

>>> hw/rtl/rotate_translate_project_vertex_top.sv
// Rotate a point about the vertical axis, add a depth offset and project it.
// Input channel: in_valid / in_stall with point_x, point_y, point_z.
// Output channel: out_valid / out_stall with proj_x, proj_y, depth and
// behind_viewer. A beat moves on an edge with valid high and stall low.
// Config: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is the
// rotation angle, index 1 the depth offset; other indexes are dropped.
// Throughput is one point per cycle unless out_stall or an angle write holds
// the flow. The stages are two rotation stages, one restoring divider cell
// per quotient bit (COORD_BITS+1 cells, both projections share each cell)
// and the output register. Sine and cosine come from a 5-stage pipeline fed
// by the angle register; after an angle write, in_stall is high as they settle.
// When out_stall is high with a beat waiting, the whole pipeline holds and
// in_stall rises. Reset empties the pipeline and loads angle 0 and offset 1.0;
// in_stall then stays high while sine and cosine fill.
module rotate_translate_project_vertex_top
	import rtpv_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] proj_x,
	output logic signed [COORD_BITS-1:0] proj_y,
	output logic signed [COORD_BITS-1:0] depth,
	output logic                         behind_viewer,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int C   = COORD_BITS;
	localparam int PW  = C + TRIG_W;
	localparam int SW  = C + TRIG_W + 1;
	localparam int RW  = C + 3;
	localparam int DW  = ((RW > 16) ? RW : 16) + 1;
	localparam int NW  = RW + FRAC_BITS;
	localparam int QW  = C + 1;
	localparam int CW  = ((DW + C > NW) ? DW + C : NW) + 1;
	localparam int NCELL = C + 1;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [DW-1:0] DMAX = DW'((64'sd1 <<< (C - 1)) - 1);
	localparam logic signed [DW-1:0] DMIN = -DMAX - DW'(1);
	localparam logic [QW-1:0] QPOS = QW'((64'd1 << (C - 1)) - 1);
	localparam logic [QW-1:0] QNEG = QW'(64'd1 << (C - 1));

	logic [15:0]              angle_q;
	logic signed [15:0]       offset_q;
	logic [2:0]               busy_q;
	logic signed [TRIG_W-1:0] sin_v, cos_v;
	logic                     en;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en || (busy_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= '0;
			offset_q <= DEPTH_OFFSET_RST;
			busy_q   <= 3'(TRIG_LAT + 1);
		end else begin
			if (busy_q != '0) begin
				busy_q <= busy_q - 3'd1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROTATION_ANGLE) begin
					angle_q <= cfg_data;
					busy_q  <= 3'(TRIG_LAT + 1);
				end else if (cfg_index == REG_DEPTH_OFFSET) begin
					offset_q <= cfg_data;
				end
			end
		end
	end

	rtpv_trig u_sin (
		.clk    (clk),
		.arst_n (arst_n),
		.phase  (angle_q),
		.sine   (sin_v)
	);

	rtpv_trig u_cos (
		.clk    (clk),
		.arst_n (arst_n),
		.phase  (angle_q + 16'd16384),
		.sine   (cos_v)
	);

	// stage 1: products
	logic                 v_s1;
	logic signed [PW-1:0] xc_s1, zs_s1, xs_s1, zc_s1;
	logic signed [C-1:0]  py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && (busy_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1 <= PW'(point_x) * PW'(cos_v);
			zs_s1 <= PW'(point_z) * PW'(sin_v);
			xs_s1 <= PW'(point_x) * PW'(sin_v);
			zc_s1 <= PW'(point_z) * PW'(cos_v);
			py_s1 <= point_y;
		end
	end

	// stage 2: round, offset, behind test, depth clamp, signs and magnitudes
	logic signed [SW-1:0] sum_x, sum_z;
	logic signed [RW-1:0] rx, rz;
	logic signed [DW-1:0] dsum;
	logic                 behind;
	logic [RW-1:0]        mag_x, mag_y;
	logic [C-1:0]         depth_sat;

	assign sum_x  = SW'(xc_s1) - SW'(zs_s1) + HALF;
	assign sum_z  = SW'(xs_s1) + SW'(zc_s1) + HALF;
	assign rx     = sum_x[SW-1:TRIG_FRAC];
	assign rz     = sum_z[SW-1:TRIG_FRAC];
	assign dsum   = DW'(rz) + DW'(offset_q);
	assign behind = dsum <= 0;
	assign mag_x  = rx[RW-1] ? RW'(-rx) : RW'(rx);
	assign mag_y  = py_s1[C-1] ? RW'(-RW'(py_s1)) : RW'(py_s1);

	always_comb begin
		priority if (dsum > DMAX) begin
			depth_sat = DMAX[C-1:0];
		end else if (dsum < DMIN) begin
			depth_sat = DMIN[C-1:0];
		end else begin
			depth_sat = dsum[C-1:0];
		end
	end

	rtpv_ctl_t             ctl_c [NCELL+1];
	logic [NW-1:0]         rx_c  [NCELL+1];
	logic [NW-1:0]         ry_c  [NCELL+1];
	logic [DW-1:0]         den_c [NCELL+1];
	logic [QW-1:0]         qx_c  [NCELL+1];
	logic [QW-1:0]         qy_c  [NCELL+1];
	logic [C-1:0]          dep_c [NCELL+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (en) begin
			ctl_c[0].valid  <= v_s1;
			ctl_c[0].behind <= behind;
			ctl_c[0].neg_x  <= rx[RW-1];
			ctl_c[0].neg_y  <= py_s1[C-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_c[0]  <= NW'(mag_x) << FRAC_BITS;
			ry_c[0]  <= NW'(mag_y) << FRAC_BITS;
			// keep the divider fed with a legal divisor when behind
			den_c[0] <= behind ? DW'(1) : dsum;
			qx_c[0]  <= '0;
			qy_c[0]  <= '0;
			dep_c[0] <= depth_sat;
		end
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rtpv_div_cell #(
			.NW (NW), .DW (DW), .QW (QW), .CW (CW), .CB (C), .K (C - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.ctl_in    (ctl_c[i]),
			.rx_in     (rx_c[i]),
			.ry_in     (ry_c[i]),
			.den_in    (den_c[i]),
			.qx_in     (qx_c[i]),
			.qy_in     (qy_c[i]),
			.depth_in  (dep_c[i]),
			.ctl_out   (ctl_c[i+1]),
			.rx_out    (rx_c[i+1]),
			.ry_out    (ry_c[i+1]),
			.den_out   (den_c[i+1]),
			.qx_out    (qx_c[i+1]),
			.qy_out    (qy_c[i+1]),
			.depth_out (dep_c[i+1])
		);
	end

	// output register: sign and saturate the quotients, zero them when behind
	rtpv_ctl_t    ctl_f;
	logic [QW-1:0] qx_f, qy_f;
	logic [C-1:0]  px_n, py_n;

	assign ctl_f = ctl_c[NCELL];
	assign qx_f  = qx_c[NCELL];
	assign qy_f  = qy_c[NCELL];

	always_comb begin
		priority if (ctl_f.behind) begin
			px_n = '0;
		end else if (!ctl_f.neg_x) begin
			px_n = (qx_f > QPOS) ? QPOS[C-1:0] : qx_f[C-1:0];
		end else begin
			px_n = (qx_f >= QNEG) ? QNEG[C-1:0] : C'(-qx_f);
		end
		priority if (ctl_f.behind) begin
			py_n = '0;
		end else if (!ctl_f.neg_y) begin
			py_n = (qy_f > QPOS) ? QPOS[C-1:0] : qy_f[C-1:0];
		end else begin
			py_n = (qy_f >= QNEG) ? QNEG[C-1:0] : C'(-qy_f);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			proj_x        <= px_n;
			proj_y        <= py_n;
			depth         <= dep_c[NCELL];
			behind_viewer <= ctl_f.behind;
		end
	end

endmodule

>>> hw/rtl/rtpv_checker.sv
module rtpv_checker
	import rtpv_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [COORD_BITS-1:0] proj_x,
	input logic [COORD_BITS-1:0] proj_y,
	input logic [COORD_BITS-1:0] depth,
	input logic                  behind_viewer,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && behind_viewer |-> proj_x == '0 && proj_y == '0)
		else $error("projection not zero behind viewer");

	a_depth_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !behind_viewer |-> !depth[COORD_BITS-1] && depth != '0)
		else $error("visible point with non-positive depth");

	a_angle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == REG_ROTATION_ANGLE |=> in_stall)
		else $error("input taken while sine and cosine settle");

endmodule

bind rotate_translate_project_vertex_top rtpv_checker #(
	.COORD_BITS (COORD_BITS)
) u_rtpv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.proj_x        (proj_x),
	.proj_y        (proj_y),
	.depth         (depth),
	.behind_viewer (behind_viewer),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_index     (cfg_index)
);

>>> verif/rotate_translate_project_vertex_top_tb.sv
`timescale 1ns / 1ps

module rotate_translate_project_vertex_top_tb;
	import rtpv_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam int FW = FRAC_BITS_DEF;
	localparam int PIPE_LAT = CW + 4;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] dz;
		logic                 behind;
	} proj_beat_t;

	class projection_scoreboard;
		proj_beat_t pending[$];
		logic [15:0] angle;
		logic signed [15:0] offset;
		int mismatches;

		function new();
			angle = 16'd0;
			offset = 16'sd4096;
			mismatches = 0;
		endfunction

		function longint sine_q14(logic [15:0] phase);
			longint r;
			longint u;
			longint u2;
			longint t;
			longint v;
			r = phase[13:0];
			u = phase[14] ? (64'sd16384 - r) : r;
			u2 = (u * u) >>> 14;
			t = POLY_B - ((u2 * POLY_C) >>> 14);
			t = POLY_A - ((u2 * t) >>> 14);
			v = (u * t) >>> 14;
			return phase[15] ? -v : v;
		endfunction

		function longint clamp_coord(longint v);
			longint hi;
			hi = (64'sd1 <<< (CW - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		// Arithmetic shift on longint floors, matching the rounding rule
		function void note_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
				logic signed [CW-1:0] z);
			longint s;
			longint c;
			longint rx;
			longint rz;
			longint d;
			longint px;
			longint py;
			longint pz;
			proj_beat_t e;
			px = x;
			py = y;
			pz = z;
			s = sine_q14(angle);
			c = sine_q14(angle + 16'd16384);
			rx = (px * c - pz * s + 8192) >>> 14;
			rz = (px * s + pz * c + 8192) >>> 14;
			d = rz + longint'(offset);
			if (d <= 0) begin
				e.px = '0;
				e.py = '0;
				e.behind = 1'b1;
			end else begin
				e.px = CW'(clamp_coord((rx * (64'sd1 <<< FW)) / d));
				e.py = CW'(clamp_coord((py * (64'sd1 <<< FW)) / d));
				e.behind = 1'b0;
			end
			e.dz = CW'(clamp_coord(d));
			pending.push_back(e);
		endfunction

		function bit check_result(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
				logic signed [CW-1:0] dz, logic behind);
			proj_beat_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat px=%0d", px);
				return 0;
			end
			e = pending.pop_front();
			if (px !== e.px || py !== e.py || dz !== e.dz || behind !== e.behind) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
						e.px, e.py, e.dz, e.behind, px, py, dz, behind);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] point_x = '0;
	logic signed [CW-1:0] point_y = '0;
	logic signed [CW-1:0] point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] proj_x;
	logic signed [CW-1:0] proj_y;
	logic signed [CW-1:0] depth;
	logic behind_viewer;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	projection_scoreboard sb = new();
	bit quiet_tail = 0;
	int idle_cycles = 0;
	bit timed_out = 0;

	always #5 clk = ~clk;

	rotate_translate_project_vertex_top i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .point_x, .point_y, .point_z,
		.out_valid, .out_stall, .proj_x, .proj_y, .depth, .behind_viewer,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	// Score on the rising edge; accepted inputs are noted in the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				void'(sb.check_result(proj_x, proj_y, depth, behind_viewer));
			if (in_valid && !in_stall)
				sb.note_point(point_x, point_y, point_z);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("rotate_translate_project_vertex_top_tb failed");
			$finish;
		end
	end

	// Receiver stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_ROTATION_ANGLE) sb.angle = val;
		else if (idx == REG_DEPTH_OFFSET) sb.offset = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return CW'($urandom_range(0, 8191)) - 16'd4096;
			default: return CW'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] angles[8];
		logic [15:0] offsets[8];
		angles = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF, 16'd8192, 16'd1, 16'd0};
		offsets = '{16'd4096, 16'h7FFF, 16'h8000, 16'd0, 16'd1, 16'hF000, 16'd20000, 16'd4096};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed: extremes, zero depth, behind viewer, reset settings
		send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(16'h8000, 16'h8000, 16'h8000);
		send_point(16'h0000, 16'h0000, 16'h0000);
		send_point(16'h1000, 16'hF000, 16'hF000);
		send_point(16'h7FFF, 16'h8000, 16'hF001);
		send_point(16'h8000, 16'h7FFF, 16'h0001);
		send_point(16'hFFFF, 16'h0001, 16'hEFFF);
		send_point(16'h5555, 16'hAAAA, 16'h0000);
		write_reg(8'd7, 16'h1234);
		send_point(16'h1000, 16'h1000, 16'h0000);
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_ROTATION_ANGLE, angles[ph]);
			write_reg(REG_DEPTH_OFFSET, offsets[ph]);
			if (ph == 7) quiet_tail = 1;
			for (int k = 0; k < 190; k++)
				send_point(rand_coord(), rand_coord(), rand_coord());
		end
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
		if (sb.mismatches == 0)
			$display("rotate_translate_project_vertex_top_tb passed");
		else
			$display("rotate_translate_project_vertex_top_tb failed");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/rtpv_pkg.sv
hw/rtl/rtpv_trig.sv
hw/rtl/rtpv_div_cell.sv
hw/rtl/rotate_translate_project_vertex_top.sv
hw/rtl/rtpv_checker.sv
verif/rotate_translate_project_vertex_top_tb.sv
